[hdl/gea2_stream_cipher_macros.svh]
// assertion macros for the gea2 stream cipher
// no dependencies
`ifndef GEA2_STREAM_CIPHER_MACROS_SVH
`define GEA2_STREAM_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GEA2_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gea2 check failed");
`define GEA2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gea2 check failed");
`else
`define GEA2_ASSERT_IMPL(label, ante, cons)
`define GEA2_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/gea2_pkg.sv]
// package for the gea2 stream cipher: types, constants, feedback functions
// no dependencies
`default_nettype none
package gea2_pkg;
    localparam logic [28:0] TAPS_D = 29'h1A59ABF9;
    localparam logic [30:0] TAPS_A = 31'h5DD89B8D;
    localparam logic [31:0] TAPS_B = 32'hF1C0F045;
    localparam logic [32:0] TAPS_C = 33'h150E6FA24;
    localparam int W_BITS = 97;
    localparam int IV_CLOCKS = 32;
    localparam int KEY_CLOCKS = 64;
    localparam int ZERO_CLOCKS = 194;
    localparam int CNT_W = 9;
    localparam logic [1:0] REG_KEY = 2'd0;
    localparam logic [1:0] REG_IV = 2'd1;
    localparam logic [1:0] REG_DIR = 2'd2;

    typedef enum logic [1:0]
    {
        OP_HOLD = 2'd0,
        OP_CLEAR = 2'd1,
        OP_W = 2'd2,
        OP_LFSR = 2'd3
    } op_t;

    typedef struct packed
    {
        op_t             op;
        logic [CNT_W-1:0] idx;
        logic            fix;
        logic            gen;
    } dp_cmd_t;

    function automatic logic nl_fun(input logic a, input logic b, input logic c,
                                    input logic d, input logic e, input logic g,
                                    input logic h);
        nl_fun = (a&c&g&h) ^ (a&d&g&h) ^ (a&b&g&h) ^ (b&c&g&h) ^ (a&c&d&h) ^
                 (b&d&e&h) ^ (b&d&g&h) ^ (a&c&e) ^ (a&c&d) ^ (a&b&d) ^ (a&c&h) ^
                 (a&b&e) ^ (a&b&h) ^ (b&c&h) ^ (c&g&h) ^ (a&d&g) ^ (b&e&h) ^
                 (b&c&g) ^ (a&d) ^ (a&g) ^ (b&d) ^ (b&g) ^ (b&h) ^ (a&c) ^ b ^
                 (c&d) ^ (c&g) ^ (c&h) ^ (e&g) ^ (g&h) ^ c ^ d ^ g;
    endfunction
endpackage
`default_nettype wire

[hdl/gea2_ctrl.sv]
// controller for the gea2 stream cipher: sequences initialization and byte output
// depends on gea2_pkg
`default_nettype none
module gea2_ctrl
    import gea2_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire logic    first,
    input  wire logic    out_busy,
    output dp_cmd_t      cmd,
    output logic         ready
);
    typedef enum logic [3:0]
    {
        S_IDLE  = 4'b0001,
        S_W     = 4'b0010,
        S_LFSR  = 4'b0100,
        S_GEN   = 4'b1000
    } state_t;

    localparam int W_TOTAL = IV_CLOCKS + 1 + KEY_CLOCKS + ZERO_CLOCKS;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '{op: OP_HOLD, idx: cnt_reg, fix: 1'b0, gen: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next = '0;
                    if (first)
                    begin
                        cmd.op = OP_CLEAR;
                        state_next = S_W;
                    end
                    else
                    begin
                        state_next = S_GEN;
                    end
                end
            end
            S_W:
            begin
                cmd.op = OP_W;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W_TOTAL - 1))
                begin
                    cnt_next = '0;
                    state_next = S_LFSR;
                end
            end
            S_LFSR:
            begin
                cmd.op = OP_LFSR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W_BITS - 1))
                begin
                    cmd.fix = 1'b1;
                    state_next = S_GEN;
                end
            end
            S_GEN:
            begin
                cmd.gen = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[hdl/gea2_dp.sv]
// datapath for the gea2 stream cipher: w register, four lfsrs, keystream byte
// depends on gea2_pkg
`default_nettype none
module gea2_dp
    import gea2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  dp_cmd_t          cmd,
    input  wire logic [63:0] key,
    input  wire logic [31:0] iv,
    input  wire logic        dir,
    output logic [7:0]       ks_byte
);
    logic [96:0] w_reg, w_next;
    logic [28:0] d_reg, d_next;
    logic [30:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [32:0] c_reg, c_next;

    logic       w_in, fb;
    logic [6:0] pa, pb, pc, pd;
    logic [7:0] ks;

    function automatic logic [6:0] wpos(input logic [CNT_W-1:0] i, input int off);
        logic [CNT_W-1:0] s;
        s = i + CNT_W'(off);
        if (s >= CNT_W'(W_BITS))
            s = s - CNT_W'(W_BITS);
        wpos = s[6:0];
    endfunction

    always_comb
    begin
        logic [28:0] d;
        logic [30:0] a;
        logic [31:0] b;
        logic [32:0] c;
        if (cmd.idx < CNT_W'(IV_CLOCKS))
            w_in = iv[cmd.idx[4:0]];
        else if (cmd.idx == CNT_W'(IV_CLOCKS))
            w_in = dir;
        else if (cmd.idx < CNT_W'(IV_CLOCKS + 1 + KEY_CLOCKS))
            w_in = key[6'(cmd.idx - CNT_W'(IV_CLOCKS + 1))];
        else
            w_in = 1'b0;
        fb = nl_fun(w_reg[4], w_reg[18], w_reg[33], w_reg[57], w_reg[63],
                    w_reg[83], w_reg[96]);
        pd = wpos(cmd.idx, 0);
        pa = wpos(cmd.idx, 16);
        pb = wpos(cmd.idx, 33);
        pc = wpos(cmd.idx, 51);

        w_next = w_reg;
        d_next = d_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        ks = '0;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                w_next = '0;
                d_next = '0;
                a_next = '0;
                b_next = '0;
                c_next = '0;
            end
            OP_W:
                w_next = {w_in ^ fb ^ w_reg[0], w_reg[96:1]};
            OP_LFSR:
            begin
                d_next = (d_reg >> 1) ^ ((d_reg[0] ^ w_reg[pd]) ? TAPS_D : '0);
                a_next = (a_reg >> 1) ^ ((a_reg[0] ^ w_reg[pa]) ? TAPS_A : '0);
                b_next = (b_reg >> 1) ^ ((b_reg[0] ^ w_reg[pb]) ? TAPS_B : '0);
                c_next = (c_reg >> 1) ^ ((c_reg[0] ^ w_reg[pc]) ? TAPS_C : '0);
                if (cmd.fix)
                begin
                    if (d_next == '0) d_next = 29'd1;
                    if (a_next == '0) a_next = 31'd1;
                    if (b_next == '0) b_next = 32'd1;
                    if (c_next == '0) c_next = 33'd1;
                end
            end
            default:
            begin
            end
        endcase

        // eight keystream steps, one byte per gen command
        d = d_reg;
        a = a_reg;
        b = b_reg;
        c = c_reg;
        for (int j = 0; j < 8; j++)
        begin
            ks[j] = nl_fun(d[12], d[23], d[3], d[0], d[10], d[27], d[17]) ^
                    nl_fun(a[22], a[0], a[13], a[21], a[25], a[2], a[7]) ^
                    nl_fun(b[12], b[27], b[0], b[1], b[29], b[21], b[5]) ^
                    nl_fun(c[10], c[30], c[32], c[3], c[19], c[0], c[4]);
            d = (d >> 1) ^ (d[0] ? TAPS_D : '0);
            a = (a >> 1) ^ (a[0] ? TAPS_A : '0);
            b = (b >> 1) ^ (b[0] ? TAPS_B : '0);
            c = (c >> 1) ^ (c[0] ? TAPS_C : '0);
        end
        if (cmd.gen)
        begin
            d_next = d;
            a_next = a;
            b_next = b;
            c_next = c;
        end
    end

    assign ks_byte = ks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            d_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
            d_reg <= d_next;
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end
endmodule
`default_nettype wire

[hdl/gea2_stream_cipher.sv]
// top level of the gea2 stream cipher: config registers, controller, datapath, output stage
// depends on gea2_pkg, gea2_ctrl, gea2_dp and gea2_stream_cipher_macros.svh
`default_nettype none
`include "gea2_stream_cipher_macros.svh"
// GEA-2 keystream cipher on a byte stream. Each input transaction carries one byte;
// the output transaction returns the byte XOR 8 keystream bits and the keystream byte,
// first generated bit in bit 0. A byte without first_of_message goes through the
// S_GEN state into the output register, and the next byte can be accepted only once
// the controller is back in S_IDLE, so a new byte is never taken before the last one
// is done. A byte with first_of_message first clocks the 97-bit W register 291 times
// (IV, direction, key, zeros), then loads the four LFSRs from W, one W bit per LFSR
// per cycle, and then goes through S_GEN into the output register. Key, IV and
// direction are written through cfg_write/cfg_index/cfg_data and take effect at the
// next first_of_message byte. One byte is in flight at a time; a new byte is accepted
// only when the block is idle and the output register is empty or being read in the
// same cycle, so a result that waits on out_ready also holds off the input.
module gea2_stream_cipher
    import gea2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_in,
    input  wire logic        first_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_out,
    output logic [7:0]       keystream_out
);
    logic [63:0] key_reg;
    logic [31:0] iv_reg;
    logic        dir_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    logic [7:0]  data_out_reg, ks_out_reg;
    logic        in_fire, busy_hold, ready;
    logic [7:0]  ks_byte;
    dp_cmd_t     cmd;

    assign in_fire = in_valid && in_ready;
    // generation may only finish into a free or draining output register
    assign busy_hold = 1'b0;

    gea2_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .first    (first_of_message),
        .out_busy (busy_hold),
        .cmd      (cmd),
        .ready    (ready)
    );

    gea2_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key     (key_reg),
        .iv      (iv_reg),
        .dir     (dir_reg),
        .ks_byte (ks_byte)
    );

    // accept only when idle and the output stage will be free by the gen cycle
    assign in_ready = ready && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg <= '0;
            dir_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEY: key_reg <= cfg_data;
                    REG_IV:  iv_reg <= cfg_data[31:0];
                    REG_DIR: dir_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.gen)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            byte_reg <= data_in;
        if (cmd.gen)
        begin
            data_out_reg <= byte_reg ^ ks_byte;
            ks_out_reg <= ks_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out = data_out_reg;
    assign keystream_out = ks_out_reg;

    // a result is produced only into an empty or draining output register
    `GEA2_ASSERT_IMPL(a_no_overwrite, cmd.gen, !out_valid_reg || out_ready)
    // gen leaves a valid result next cycle
    `GEA2_ASSERT_NEXT(a_gen_valid, cmd.gen, out_valid_reg)
    // no input taken while a byte is in flight
    `GEA2_ASSERT_IMPL(a_one_in_flight, cmd.op != OP_HOLD && cmd.op != OP_CLEAR, !in_ready)
endmodule
`default_nettype wire

[verif/gea2_stream_cipher_tb.sv]
// self-checking testbench for the gea2 stream cipher: directed table, then random messages
// depends on gea2_pkg and gea2_stream_cipher; keystream predicted by an in-bench cipher model
`default_nettype none
module gea2_stream_cipher_tb;
    import gea2_pkg::*;

    // index with no register behind it, writes there are dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_in;
    logic        first_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  data_out;
    logic [7:0]  keystream_out;

    gea2_stream_cipher dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_in(data_in),
        .first_of_message(first_of_message),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data_out(data_out),
        .keystream_out(keystream_out)
    );

    // one expected output transaction
    typedef struct
    {
        logic [7:0] cipher_byte;
        logic [7:0] ks_byte;
    } cipher_result_t;

    // directed stimulus row; when load_regs is set the registers are rewritten first
    typedef struct
    {
        logic        load_regs;
        logic [63:0] key;
        logic [31:0] iv;
        logic        dir;
        logic [7:0]  byte_val;
        logic        flag;
        logic        typed;
        logic [7:0]  typed_ks;
    } stim_row_t;

    cipher_result_t expected_bytes[$];

    // model copy of the configuration registers
    logic [63:0] key_reg;
    logic [31:0] iv_reg;
    logic        dir_reg;

    // model copy of the cipher state: W and the four LFSRs, kept 33 bits wide
    logic [96:0] w_reg;
    logic [32:0] lfsr_d;
    logic [32:0] lfsr_a;
    logic [32:0] lfsr_b;
    logic [32:0] lfsr_c;

    int mismatches;
    int cycles;
    int items_sent;
    bit tx_no_idle;
    bit rx_no_idle;
    int rx_hold;

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------

    // 7-input boolean function shared by W feedback and keystream output
    function automatic logic mix7(input logic a, input logic b, input logic c, input logic d,
                                  input logic e, input logic g, input logic h);
        logic t4;
        logic t3;
        logic t2;
        t4 = (a&c&g&h) ^ (a&d&g&h) ^ (a&b&g&h) ^ (b&c&g&h) ^ (a&c&d&h) ^ (b&d&e&h) ^
             (b&d&g&h);
        t3 = (a&c&e) ^ (a&c&d) ^ (a&b&d) ^ (a&c&h) ^ (a&b&e) ^ (a&b&h) ^ (b&c&h) ^
             (c&g&h) ^ (a&d&g) ^ (b&e&h) ^ (b&c&g);
        t2 = (a&d) ^ (a&g) ^ (b&d) ^ (b&g) ^ (b&h) ^ (a&c) ^ (c&d) ^ (c&g) ^ (c&h) ^
             (e&g) ^ (g&h);
        return t4 ^ t3 ^ t2 ^ b ^ c ^ d ^ g;
    endfunction

    function automatic logic [32:0] galois_step(input logic [32:0] s, input logic [32:0] taps,
                                                input logic in_bit);
        logic [32:0] n;
        n = s >> 1;
        if (s[0] ^ in_bit)
            n = n ^ taps;
        return n;
    endfunction

    task automatic clock_w(input logic in_bit);
        logic fb;
        fb = mix7(w_reg[4], w_reg[18], w_reg[33], w_reg[57], w_reg[63], w_reg[83], w_reg[96]);
        w_reg = {in_bit ^ fb ^ w_reg[0], w_reg[96:1]};
    endtask

    // full key and iv setup, as run for a byte flagged first of message
    task automatic run_key_setup();
        w_reg = '0;
        for (int i = 0; i < IV_CLOCKS; i++)
            clock_w(iv_reg[i]);
        clock_w(dir_reg);
        for (int i = 0; i < KEY_CLOCKS; i++)
            clock_w(key_reg[i]);
        for (int i = 0; i < ZERO_CLOCKS; i++)
            clock_w(1'b0);
        lfsr_d = '0;
        lfsr_a = '0;
        lfsr_b = '0;
        lfsr_c = '0;
        for (int i = 0; i < W_BITS; i++)
        begin
            lfsr_d = galois_step(lfsr_d, 33'(TAPS_D), w_reg[i]);
            lfsr_a = galois_step(lfsr_a, 33'(TAPS_A), w_reg[(i + 16) % W_BITS]);
            lfsr_b = galois_step(lfsr_b, 33'(TAPS_B), w_reg[(i + 33) % W_BITS]);
            lfsr_c = galois_step(lfsr_c, 33'(TAPS_C), w_reg[(i + 51) % W_BITS]);
        end
        // an all-zero lfsr would lock up, so it is forced to one
        if (lfsr_d == '0) lfsr_d = 33'd1;
        if (lfsr_a == '0) lfsr_a = 33'd1;
        if (lfsr_b == '0) lfsr_b = 33'd1;
        if (lfsr_c == '0) lfsr_c = 33'd1;
    endtask

    task automatic next_keystream_byte(output logic [7:0] ks);
        logic z;
        ks = '0;
        for (int j = 0; j < 8; j++)
        begin
            z = mix7(lfsr_d[12], lfsr_d[23], lfsr_d[3], lfsr_d[0], lfsr_d[10], lfsr_d[27],
                     lfsr_d[17]) ^
                mix7(lfsr_a[22], lfsr_a[0], lfsr_a[13], lfsr_a[21], lfsr_a[25], lfsr_a[2],
                     lfsr_a[7]) ^
                mix7(lfsr_b[12], lfsr_b[27], lfsr_b[0], lfsr_b[1], lfsr_b[29], lfsr_b[21],
                     lfsr_b[5]) ^
                mix7(lfsr_c[10], lfsr_c[30], lfsr_c[32], lfsr_c[3], lfsr_c[19], lfsr_c[0],
                     lfsr_c[4]);
            ks[j] = z;
            lfsr_d = galois_step(lfsr_d, 33'(TAPS_D), 1'b0);
            lfsr_a = galois_step(lfsr_a, 33'(TAPS_A), 1'b0);
            lfsr_b = galois_step(lfsr_b, 33'(TAPS_B), 1'b0);
            lfsr_c = galois_step(lfsr_c, 33'(TAPS_C), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_KEY: key_reg = val;
            REG_IV:  iv_reg = val[31:0];
            REG_DIR: dir_reg = val[0];
            default: ;
        endcase
    endtask

    // sender pauses until every expected result is back, then the block is idle
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one input transaction; the expectation is queued when it is accepted
    task automatic send_byte(input logic [7:0] val, input logic flag, input logic typed,
                             input logic [7:0] typed_ks);
        int gap;
        logic [7:0] ks;
        cipher_result_t res;
        gap = tx_no_idle ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_in <= val;
        first_of_message <= flag;
        do
            @(posedge clk);
        while (!in_ready);
        if (flag)
            run_key_setup();
        next_keystream_byte(ks);
        if (typed)
            ks = typed_ks;
        res.cipher_byte = val ^ ks;
        res.ks_byte = ks;
        expected_bytes.push_back(res);
        items_sent++;
    endtask

    function automatic logic [63:0] pick_value(input int bits);
        logic [63:0] v;
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = '1;
        else
            v = {$urandom, $urandom};
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // output side: random backpressure and checking
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        rx_hold = 0;
        forever
        begin
            @(negedge clk);
            if (rx_no_idle)
            begin
                out_ready <= 1'b1;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    rx_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transaction: data %h ks %h",
                             data_out, keystream_out);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (data_out !== want.cipher_byte || keystream_out !== want.ks_byte)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: data exp %h got %h, ks exp %h got %h",
                                 want.cipher_byte, data_out, want.ks_byte, keystream_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    stim_row_t directed_rows[] = '{
        // no setup since reset: keystream is zero, bytes pass through
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hFF, 1'b0, 1'b1, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h5A, 1'b0, 1'b1, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hA5, 1'b0, 1'b1, 8'h00},
        // setup with all-zero key, iv and direction
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h3C, 1'b0, 1'b0, 8'h00},
        // all-ones registers; the old stream keeps running until the next flag
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h11, 1'b0, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h22, 1'b0, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
        // flag on consecutive bytes restarts the same stream
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h80, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h01, 1'b1, 1'b0, 8'h00},
        // direction bit alone differs
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h01, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hFE, 1'b0, 1'b0, 8'h00},
        // mixed extremes: key zero with iv all ones, then the reverse
        '{1'b1, 64'h0, 32'hFFFF_FFFF, 1'b1, 8'h7F, 1'b1, 1'b0, 8'h00},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, 8'hC3, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'h96, 1'b0, 1'b0, 8'h00},
        '{1'b1, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 1'b1, 8'h55, 1'b1, 1'b0, 8'h00},
        '{1'b0, 64'h0, 32'h0, 1'b0, 8'hAA, 1'b0, 1'b0, 8'h00}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int msg_count;
        int msg_len;
        cycles = 0;
        mismatches = 0;
        items_sent = 0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        key_reg = '0;
        iv_reg = '0;
        dir_reg = 1'b0;
        w_reg = '0;
        lfsr_d = '0;
        lfsr_a = '0;
        lfsr_b = '0;
        lfsr_c = '0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY;
        cfg_data = '0;
        in_valid = 1'b0;
        data_in = '0;
        first_of_message = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load_regs)
            begin
                drain_outputs();
                write_reg(REG_KEY, directed_rows[i].key);
                write_reg(REG_IV, {$urandom, directed_rows[i].iv});
                write_reg(REG_DIR, {63'(0), directed_rows[i].dir});
                // dropped write must not disturb the key
                write_reg(REG_UNUSED, {$urandom, $urandom});
            end
            send_byte(directed_rows[i].byte_val, directed_rows[i].flag,
                      directed_rows[i].typed, directed_rows[i].typed_ks);
        end

        // random phases: idle config update, then a few messages
        while (items_sent < ITEM_TARGET)
        begin
            drain_outputs();
            tx_no_idle = ($urandom_range(0, 5) == 0);
            rx_no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 1)) write_reg(REG_KEY, pick_value(64));
            if ($urandom_range(0, 1)) write_reg(REG_IV, {$urandom, 32'(pick_value(32))});
            if ($urandom_range(0, 1)) write_reg(REG_DIR, {$urandom, $urandom});
            if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
            // some phases open with stray bytes that continue the previous stream
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom), 1'b0, 1'b0, 8'h00);
            msg_count = $urandom_range(1, 3);
            repeat (msg_count)
            begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 25);
                send_byte(8'($urandom), 1'b1, 1'b0, 8'h00);
                repeat (msg_len - 1)
                    send_byte(8'($urandom), 1'b0, 1'b0, 8'h00);
            end
        end

        drain_outputs();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/gea2_pkg.sv
hdl/gea2_ctrl.sv
hdl/gea2_dp.sv
hdl/gea2_stream_cipher.sv
verif/gea2_stream_cipher_tb.sv
